// ===== rtl/core/sidec_pkg.sv =====
// sidec_pkg: widths and character codes for the signed decimal text converter.
// No dependencies; imported by signed_int_to_decimal_ascii.
package sidec_pkg;

  localparam int unsigned NUM_W    = 32;  // input integer width
  localparam int unsigned NDIGITS  = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned BCD_W    = 4 * NDIGITS;
  localparam int unsigned CHAR_W   = 6;
  localparam int unsigned OUT_TD_W = 8;   // character padded to a byte

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef logic [3:0] bcd_digit_t;

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text stream.
// Depends on sidec_pkg (widths, ASCII codes).
//
// Each input word is a signed 32-bit integer; the block sends its decimal text one
// character per output word, most significant digit first, no leading zeros, with
// a leading '-' for negative values and a single '0' for zero. The final character
// of a run carries tlast. -2147483648 gives "-2147483648". One number is worked on
// at a time: it is loaded, converted by bit-serial shift-and-add-3 over all 32 bits,
// stripped of leading zero digits one at a time, then its characters are sent one
// by one, each once the sink has room. Dropped and sent digits always add up to ten.
// With an always-ready sink, most of the time spent on a number goes to the
// bit-serial BCD conversion loop; stalls by the sink lengthen it. The next number
// is accepted as soon as the last character is in the output register, even while
// it waits to be taken.
module signed_int_to_decimal_ascii
  import sidec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [NUM_W-1:0]    in_tdata,   // [31:0] number
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,  // [5:0] character, [7:6] zero
  output logic                out_tlast   // last
);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic [NUM_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [4:0]        bit_cnt_r, bit_cnt_nxt;
  logic [3:0]        dig_cnt_r, dig_cnt_nxt;  // digits still held in bcd_r
  logic              sign_r, sign_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;

  logic [BCD_W-1:0]  bcd_adj;
  logic              slot_free;
  bcd_digit_t        top_digit;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_TD_W-CHAR_W){1'b0}}, ochar_r};
  assign out_tlast  = olast_r;

  assign slot_free = !ovalid_r || out_tready;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NDIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                    : bcd_r[4*d +: 4];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    sign_nxt    = sign_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    ochar_nxt   = ochar_r;
    olast_nxt   = olast_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // two's complement negate; the most negative value maps to 2^31
          mag_nxt     = in_tdata[NUM_W-1] ? (~in_tdata + 32'd1) : in_tdata;
          sign_nxt    = in_tdata[NUM_W-1];
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[NUM_W-1]};
        mag_nxt     = {mag_r[NUM_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'(NUM_W-1)) begin
          dig_cnt_nxt = 4'(NDIGITS);
          state_nxt   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // keep at least one digit so zero prints as '0'
        if (top_digit == 4'd0 && dig_cnt_r > 4'd1) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - 4'd1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          if (sign_r) begin
            ochar_nxt = ASCII_MINUS;
            olast_nxt = 1'b0;
            sign_nxt  = 1'b0;
          end else begin
            ochar_nxt   = ASCII_ZERO + {2'b00, top_digit};
            olast_nxt   = (dig_cnt_r == 4'd1);
            bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
            dig_cnt_nxt = dig_cnt_r - 4'd1;
            if (dig_cnt_r == 4'd1) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sign_r    <= 1'b0;
      ovalid_r  <= 1'b0;
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      sign_r    <= sign_nxt;
      ovalid_r  <= ovalid_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      dig_cnt_r <= dig_cnt_nxt;
    end
    mag_r   <= mag_nxt;
    bcd_r   <= bcd_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  // only '-' or a decimal digit ever leaves the block
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ochar_r == ASCII_MINUS) ||
                 (ochar_r >= ASCII_ZERO && ochar_r <= ASCII_ZERO + 6'd9))
    else $error("character out of range");

  // a sign is never the end of a run
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ochar_r == ASCII_MINUS) |-> !olast_r)
    else $error("minus sign flagged last");

  // conversion leaves valid BCD in the top digit
  a_bcd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SKIP || state_r == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("top BCD digit above nine");

  // a run ends with its last character in the output register, flagged last
  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_IDLE) |=> (ovalid_r && olast_r))
    else $error("run ended without last character");

endmodule

// ===== verif/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps
// signed_int_to_decimal_ascii_tb: self-checking bench for the signed integer to decimal text
// converter; predicts the character run of each accepted number and checks the output stream.
// Depends on sidec_pkg and signed_int_to_decimal_ascii.
module signed_int_to_decimal_ascii_tb;
  import sidec_pkg::*;

  localparam int unsigned DECIMAL_BASE = 10;
  localparam int unsigned RANDOM_NUMBERS = 470;
  localparam int unsigned SETTLE_CYCLES = 60;  // extra cycles run after the last expected character is checked

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  typedef struct {
    logic [NUM_W-1:0] number;
    bit               hold_for_drain;  // wait for the output to empty before sending
  } number_word_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [NUM_W-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;
  logic                out_tlast;

  number_word_t numbers_to_send[$];
  text_char_t   text_expected[$];

  bit         in_taken = 1'b0;
  int         burst_left = 1;
  int         gap_left = 0;
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_cycles = 0;

  int mismatches = 0;
  int numbers_sent = 0;
  int negatives_sent = 0;
  int zeros_sent = 0;
  int longest_runs = 0;
  int chars_checked = 0;

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decimal text of one number, pushed onto the expected character queue.
  function automatic void predict_text(input logic [NUM_W-1:0] number);
    logic [NUM_W-1:0] magnitude;
    bcd_digit_t       digits[NDIGITS];
    int               ndig;
    magnitude = number[NUM_W-1] ? (~number + 1'b1) : number;
    ndig = 0;
    do begin
      digits[ndig] = bcd_digit_t'(magnitude % DECIMAL_BASE);
      magnitude = magnitude / DECIMAL_BASE;
      ndig++;
    end while (magnitude != 0 && ndig < NDIGITS);
    if (number[NUM_W-1])
      text_expected.push_back('{ASCII_MINUS, 1'b0});
    for (int i = ndig - 1; i >= 0; i--)
      text_expected.push_back('{ASCII_ZERO + CHAR_W'(digits[i]), (i == 0)});
  endfunction

  // Mostly spread over digit counts so short and long runs both show up often.
  function automatic logic [NUM_W-1:0] pick_number();
    int     kind;
    int     ndig;
    longint lo;
    longint hi;
    longint value;
    kind = $urandom_range(0, 9);
    if (kind < 3)
      return $urandom();
    if (kind == 3) begin
      value = $urandom_range(0, 20);
    end else begin
      ndig = $urandom_range(1, NDIGITS);
      lo = 1;
      for (int i = 1; i < ndig; i++)
        lo = lo * DECIMAL_BASE;
      hi = lo * DECIMAL_BASE - 1;
      if (hi > 64'sd2147483647)
        hi = 64'sd2147483647;
      value = lo + (longint'($urandom()) % (hi - lo + 1));
    end
    if ($urandom_range(0, 1))
      value = -value;
    return NUM_W'(value);
  endfunction

  // Sender: bursts of words with random gaps, holding a word until it is taken.
  always @(negedge clk) begin : driver
    number_word_t word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (numbers_to_send.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (numbers_to_send[0].hold_for_drain && text_expected.size() != 0) begin
        in_tvalid <= 1'b0;
      end else begin
        word = numbers_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= word.number;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 4) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end
    end
  end

  // Receiver: switches between stall patterns, each kept for a random stretch.
  always @(negedge clk) begin : sink
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (sink_cycles == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_cycles = $urandom_range(16, 96);
      end
      sink_cycles--;
      case (sink_mode)
        SINK_OPEN:   out_tready <= 1'b1;
        SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: out_tready <= ($urandom_range(0, 5) == 0);
        default:     out_tready <= ~out_tready;
      endcase
    end
  end

  // Output is checked before the new number is predicted: a character taken on the
  // same edge as an input word always belongs to an earlier number.
  always @(posedge clk) begin : monitor
    text_char_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (text_expected.size() == 0) begin
          $display("%0t: unexpected word, actual char %0d last %0b",
                   $time, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = text_expected.pop_front();
          chars_checked++;
          if (out_tdata[CHAR_W-1:0] !== want.character || out_tlast !== want.last) begin
            $display("%0t: expected char %0d last %0b, actual char %0d last %0b",
                     $time, want.character, want.last, out_tdata[CHAR_W-1:0], out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
        numbers_sent++;
        if (in_tdata[NUM_W-1])
          negatives_sent++;
        if (in_tdata == '0)
          zeros_sent++;
        if (in_tdata == {1'b1, {(NUM_W-1){1'b0}}})
          longest_runs++;
      end
    end
  end

  initial begin
    // Directed: sign and digit-count boundaries, the most negative value, zero, bit patterns.
    numbers_to_send.push_back('{32'd0, 1'b0});
    numbers_to_send.push_back('{32'd1, 1'b0});
    numbers_to_send.push_back('{-32'sd1, 1'b0});
    numbers_to_send.push_back('{32'd9, 1'b0});
    numbers_to_send.push_back('{32'd10, 1'b0});
    numbers_to_send.push_back('{-32'sd10, 1'b0});
    numbers_to_send.push_back('{32'd99, 1'b0});
    numbers_to_send.push_back('{32'd100, 1'b0});
    numbers_to_send.push_back('{-32'sd9, 1'b0});
    numbers_to_send.push_back('{32'h7FFF_FFFF, 1'b0});
    numbers_to_send.push_back('{32'h8000_0000, 1'b0});
    numbers_to_send.push_back('{32'h8000_0001, 1'b0});
    numbers_to_send.push_back('{32'd1000000000, 1'b0});
    numbers_to_send.push_back('{32'd999999999, 1'b0});
    numbers_to_send.push_back('{-32'sd999999999, 1'b0});
    numbers_to_send.push_back('{-32'sd1000000000, 1'b0});
    numbers_to_send.push_back('{32'd1234567890, 1'b0});
    numbers_to_send.push_back('{32'd1000000, 1'b0});
    numbers_to_send.push_back('{32'h5555_5555, 1'b0});
    numbers_to_send.push_back('{32'hAAAA_AAAA, 1'b0});
    numbers_to_send.push_back('{32'd0, 1'b0});
    numbers_to_send.push_back('{32'h8000_0000, 1'b0});
    for (int k = 0; k < RANDOM_NUMBERS; k++)
      numbers_to_send.push_back('{pick_number(), (k % 120 == 0)});

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    do @(negedge clk);
    while (numbers_to_send.size() != 0 || in_tvalid || text_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("converted %0d numbers (%0d negative, %0d zero, %0d most negative)",
             numbers_sent, negatives_sent, zeros_sent, longest_runs);
    $display("checked %0d characters under random input gaps and output stalls",
             chars_checked);
    if (mismatches == 0)
      $display("signed_int_to_decimal_ascii: match");
    else
      $display("signed_int_to_decimal_ascii: mismatch");
    $finish;
  end

  initial begin
    #16ms;
    $display("timeout with %0d characters still expected", text_expected.size());
    $display("signed_int_to_decimal_ascii: mismatch");
    $finish;
  end

endmodule
